FILE: sv/sle_pkg.sv
// Shared definitions for the sequential list engine: operation codes,
// the command broadcast to the cells and the probe that walks the cell row.
// No dependencies.
`default_nettype none

package sle_pkg;

  localparam int CAPACITY_DEF = 128;

  localparam logic [2:0] OP_INS = 3'd0;
  localparam logic [2:0] OP_DEL = 3'd1;
  localparam logic [2:0] OP_GET = 3'd2;
  localparam logic [2:0] OP_LOC = 3'd3;
  localparam logic [2:0] OP_PRE = 3'd4;
  localparam logic [2:0] OP_SUC = 3'd5;
  localparam logic [2:0] OP_CLR = 3'd6;

  // Command held steady for the whole walk.
  typedef struct packed {
    logic [2:0]         op;
    logic               ok;
    logic signed [31:0] value;
  } cmd_t;

  // Probe handed from cell to cell, one cell per cycle.
  typedef struct packed {
    logic               valid;
    logic               hit;
    logic signed [31:0] res;
    logic signed [31:0] carry;
    logic [7:0]         fpos;
  } probe_t;

endpackage

`default_nettype wire

FILE: sv/sle_cell.sv
// One list cell: holds the element at a fixed index and acts on the probe
// as it passes. Depends on sle_pkg.
`default_nettype none

module sle_cell #(
  parameter int IDX = 0,
  parameter int CW  = 9
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  sle_pkg::cmd_t        cmd,
  input  wire [CW-1:0]         pos_idx,
  input  wire [CW-1:0]         len,
  input  wire signed [31:0]    left_elem,
  input  wire signed [31:0]    right_elem,
  input  sle_pkg::probe_t      probe_in,
  output sle_pkg::probe_t      probe_out,
  output logic signed [31:0]   elem_out
);
  import sle_pkg::*;

  localparam logic [CW-1:0] IDX_C  = CW'(IDX);
  localparam logic [CW-1:0] IDX1_C = CW'(IDX + 1);
  localparam logic [31:0]   IDX1_W = 32'(IDX + 1);

  logic signed [31:0] elem_r, elem_nxt;
  probe_t             probe_r, probe_nxt;
  logic               here, at, ge, live, nlive, match;

  always_comb begin
    here      = probe_in.valid;
    at        = (IDX_C == pos_idx);
    ge        = (IDX_C >= pos_idx);
    live      = (IDX_C < len);
    nlive     = (IDX1_C < len);
    match     = (elem_r == cmd.value);
    elem_nxt  = elem_r;
    probe_nxt = probe_in;
    if (here && cmd.ok) begin
      unique case (cmd.op)
        OP_INS: begin
          // swap in the carried element, pass ours on
          if (ge) begin
            elem_nxt        = probe_in.carry;
            probe_nxt.carry = elem_r;
          end
        end
        OP_DEL: begin
          if (at) probe_nxt.res = elem_r;
          if (ge) elem_nxt = right_elem;
        end
        OP_GET: begin
          if (at) probe_nxt.res = elem_r;
        end
        OP_LOC: begin
          if (live && match && !probe_in.hit) begin
            probe_nxt.hit  = 1'b1;
            probe_nxt.fpos = IDX1_W[7:0];
          end
        end
        OP_PRE: begin
          if ((IDX != 0) && live && match && !probe_in.hit) begin
            probe_nxt.hit = 1'b1;
            probe_nxt.res = left_elem;
          end
        end
        OP_SUC: begin
          if (nlive && match && !probe_in.hit) begin
            probe_nxt.hit = 1'b1;
            probe_nxt.res = right_elem;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Advance the probe one cell per clock.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r <= '0;
    end else begin
      probe_r <= probe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    elem_r <= elem_nxt;
  end

  assign probe_out = probe_r;
  assign elem_out  = elem_r;

endmodule

`default_nettype wire

FILE: sv/sequential_list_engine.sv
// Top level of the sequential list engine: command sequencer, result
// register and the row of list cells. Depends on sle_pkg and sle_cell.
//
// The list lives in a row of CAPACITY cells, one element per cell. An item
// accepted with start high and busy low launches a probe that moves one cell
// per clock along the row; each cell compares, shifts or captures as the
// probe passes, so every operation takes the same time whatever it is. The
// result strobes on out_strobe for one cycle, registered from the probe leaving
// the last cell, and busy falls together with it, so no new item is accepted
// until the last one's result is out. The walk time is set by the length of
// the cell row. The receiver cannot hold a result off: sample it on the
// strobe. Element contents are not cleared at reset; only positions below
// the current count are ever read.
`default_nettype none

module sequential_list_engine #(
  parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  input  wire [2:0]          in_operation,
  input  wire [7:0]          in_position,
  input  wire signed [31:0]  in_value,
  output logic               out_strobe,
  output logic               out_status,
  output logic signed [31:0] out_value,
  output logic [7:0]         out_found_position,
  output logic [7:0]         out_list_count
);
  import sle_pkg::*;

  localparam int IW = $clog2(CAPACITY + 1);
  // compare width: holds a position, the length and one more
  localparam int CW = ((IW > 8) ? IW : 8) + 1;

  // Sequencer state
  logic               busy_r, busy_nxt;
  logic               launch_r;
  logic [2:0]         op_r;
  logic               ok_r;
  logic signed [31:0] val_r;
  logic [CW-1:0]      pos_idx_r;
  logic [IW-1:0]      len_r, len_nxt;

  // Result registers
  logic               strobe_r;
  logic               status_r;
  logic signed [31:0] value_r;
  logic [7:0]         found_r;
  logic [7:0]         count_r;

  logic               accept;
  logic [CW-1:0]      pos_ext, len_ext;
  logic               pos_nz, ins_ok, rd_ok, ok_nxt;

  cmd_t               cmd;
  probe_t             probes [CAPACITY+1];
  logic signed [31:0] elems  [CAPACITY];
  probe_t             tail;

  logic               err;
  logic [31:0]        count_w;

  assign accept = start && !busy_r;

  // Check the position against the length as the item arrives.
  always_comb begin
    pos_ext = CW'(in_position);
    len_ext = CW'(len_r);
    pos_nz  = (in_position != 8'd0);
    ins_ok  = pos_nz && (pos_ext <= len_ext + CW'(1)) && (len_ext < CW'(CAPACITY));
    rd_ok   = pos_nz && (pos_ext <= len_ext);
    unique case (in_operation)
      OP_INS:          ok_nxt = ins_ok;
      OP_DEL, OP_GET:  ok_nxt = rd_ok;
      default:         ok_nxt = 1'b1;
    endcase
  end

  // Broadcast the held command to every cell.
  assign cmd.op    = op_r;
  assign cmd.ok    = ok_r;
  assign cmd.value = val_r;

  // Probe entering the first cell: carry starts as the value to insert.
  assign probes[0].valid = launch_r;
  assign probes[0].hit   = 1'b0;
  assign probes[0].res   = 32'sd0;
  assign probes[0].carry = val_r;
  assign probes[0].fpos  = 8'd0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = 32'sd0;
    end else begin : g_left
      assign left_w = elems[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = 32'sd0;
    end else begin : g_right
      assign right_w = elems[i+1];
    end
    sle_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .pos_idx    (pos_idx_r),
      .len        (CW'(len_r)),
      .left_elem  (left_w),
      .right_elem (right_w),
      .probe_in   (probes[i]),
      .probe_out  (probes[i+1]),
      .elem_out   (elems[i])
    );
  end

  assign tail = probes[CAPACITY];

  // Form the result and the new length as the probe leaves the row.
  always_comb begin
    unique case (op_r)
      OP_INS, OP_DEL, OP_GET: err = !ok_r;
      OP_LOC, OP_PRE, OP_SUC: err = !tail.hit;
      OP_CLR:                 err = 1'b0;
      default:                err = 1'b1;
    endcase
    len_nxt = len_r;
    if (op_r == OP_INS && ok_r) begin
      len_nxt = len_r + IW'(1);
    end else if (op_r == OP_DEL && ok_r) begin
      len_nxt = len_r - IW'(1);
    end else if (op_r == OP_CLR) begin
      len_nxt = '0;
    end
    count_w  = 32'(len_nxt);
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (tail.valid) begin
      busy_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      launch_r <= 1'b0;
      strobe_r <= 1'b0;
      len_r    <= '0;
    end else begin
      busy_r   <= busy_nxt;
      launch_r <= accept;
      strobe_r <= tail.valid;
      if (tail.valid) len_r <= len_nxt;
    end
  end

  // Hold the command; drop in the result when the probe comes out.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r      <= in_operation;
      ok_r      <= ok_nxt;
      val_r     <= in_value;
      pos_idx_r <= pos_ext - CW'(1);
    end
    if (tail.valid) begin
      status_r <= err;
      value_r  <= err ? 32'sd0 : tail.res;
      found_r  <= (op_r == OP_LOC && !err) ? tail.fpos : 8'd0;
      count_r  <= count_w[7:0];
    end
  end

  assign busy               = busy_r;
  assign out_strobe         = strobe_r;
  assign out_status         = status_r;
  assign out_value          = value_r;
  assign out_found_position = found_r;
  assign out_list_count     = count_r;

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking testbench for the sequential list engine: directed and random
// list operations, with a scoreboard class that predicts every result.
// Depends on sle_pkg and sequential_list_engine.
`timescale 1ns / 1ps

module tb_top;
  import sle_pkg::*;

  localparam int LIST_CAP = CAPACITY_DEF;
  // Operation code the block does not define; it must answer with an error.
  localparam logic [2:0] OP_UNUSED = 3'd7;

  typedef struct {
    logic               status;
    logic signed [31:0] value;
    logic [7:0]         fpos;
    logic [7:0]         count;
  } list_result_t;

  // Scoreboard: keeps its own copy of the list, predicts one result per
  // accepted item and checks results against them in order.
  class list_scoreboard;
    logic signed [31:0] elems [LIST_CAP];
    int                 fill;
    int                 errors;
    list_result_t       expected_q[$];

    function int find_first(int from, logic signed [31:0] v);
      for (int k = from; k < fill; k++)
        if (elems[k] == v) return k;
      return fill;
    endfunction

    // Pick a value that is in the list, or a random word on an empty list.
    function logic signed [31:0] pick_present();
      if (fill == 0) return $urandom;
      return elems[$urandom_range(0, fill - 1)];
    endfunction

    function void note_command(logic [2:0] op, logic [7:0] pos, logic signed [31:0] val);
      list_result_t r;
      int p;
      int k;
      p = pos;
      r.status = 1'b0;
      r.value  = '0;
      r.fpos   = '0;
      case (op)
        OP_INS: begin
          if (p < 1 || p > fill + 1 || fill >= LIST_CAP) begin
            r.status = 1'b1;
          end else begin
            // Shift the tail up by one, then drop the new word in.
            for (k = fill; k >= p; k--) elems[k] = elems[k - 1];
            elems[p - 1] = val;
            fill++;
          end
        end
        OP_DEL: begin
          if (p < 1 || p > fill) begin
            r.status = 1'b1;
          end else begin
            r.value = elems[p - 1];
            for (k = p; k < fill; k++) elems[k - 1] = elems[k];
            fill--;
          end
        end
        OP_GET: begin
          if (p < 1 || p > fill) r.status = 1'b1;
          else r.value = elems[p - 1];
        end
        OP_LOC: begin
          k = find_first(0, val);
          if (k < fill) r.fpos = 8'(k + 1);
          else r.status = 1'b1;
        end
        OP_PRE: begin
          // A match in the first position has no element before it.
          k = find_first(1, val);
          if (k < fill) r.value = elems[k - 1];
          else r.status = 1'b1;
        end
        OP_SUC: begin
          k = find_first(0, val);
          if (k + 1 < fill) r.value = elems[k + 1];
          else r.status = 1'b1;
        end
        OP_CLR: begin
          fill = 0;
        end
        default: begin
          r.status = 1'b1;
        end
      endcase
      r.count = 8'(fill);
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 100) $display("%0t mismatch: %s", $time, msg);
    endtask

    task check_result(logic status, logic signed [31:0] value, logic [7:0] fpos,
                      logic [7:0] count);
      list_result_t e;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result with no item pending: status=%0b value=%0d",
                                  status, value));
        return;
      end
      e = expected_q.pop_front();
      if (status !== e.status || value !== e.value || fpos !== e.fpos || count !== e.count)
        report_mismatch($sformatf("got status=%0b value=%0d found=%0d count=%0d, want %0b %0d %0d %0d",
                                  status, value, fpos, count,
                                  e.status, e.value, e.fpos, e.count));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic [2:0]         in_operation = '0;
  logic [7:0]         in_position = '0;
  logic signed [31:0] in_value = '0;
  logic               busy;
  logic               out_strobe;
  logic               out_status;
  logic signed [31:0] out_value;
  logic [7:0]         out_found_position;
  logic [7:0]         out_list_count;

  list_scoreboard list_sb = new();
  int burst_left = 0;

  always #5 clk = ~clk;

  sequential_list_engine u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_operation       (in_operation),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_strobe         (out_strobe),
    .out_status         (out_status),
    .out_value          (out_value),
    .out_found_position (out_found_position),
    .out_list_count     (out_list_count)
  );

  // Results cannot be held off: take each one at the edge that ends its
  // strobe cycle.
  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1)
      list_sb.check_result(out_status, out_value, out_found_position, out_list_count);
  end

  // Present one item and hold it until the block takes it. Call right after
  // a rising edge; start is left high so the next item can follow at once.
  task automatic issue_command(input logic [2:0] op, input logic [7:0] pos,
                               input logic signed [31:0] val);
    start        <= 1'b1;
    in_operation <= op;
    in_position  <= pos;
    in_value     <= val;
    do @(posedge clk); while (busy !== 1'b0);
    list_sb.note_command(op, pos, val);
  endtask

  // Drop start and hold until every pending result has come back.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (list_sb.expected_q.size() != 0);
  endtask

  // Sender pacing: bursts of random length, separated by random gaps that
  // land anywhere in the block's walk; now and then a long run with no gap.
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 4))
        0: gap = 0;
        1: gap = $urandom_range(1, 10);
        2: gap = $urandom_range(10, 140);
        3: gap = $urandom_range(140, 300);
        default: gap = 0;
      endcase
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = (gap == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
    end
    burst_left--;
  endtask

  // Word to insert: extremes, a small pool that makes duplicates, or anything.
  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2, 3: return 32'($urandom_range(0, 7) - 3);
      default: return $urandom;
    endcase
  endfunction

  // Position: mostly in range, sometimes zero, just past the end or any byte.
  function automatic logic [7:0] rand_position(int limit);
    case ($urandom_range(0, 9))
      0: return 8'($urandom_range(0, 255));
      1: return 8'd0;
      2: return 8'(limit + 1);
      default: return (limit == 0) ? 8'd1 : 8'($urandom_range(1, limit));
    endcase
  endfunction

  // Operation mix by phase: 0 grows the list, 1 shrinks it, 2 is mixed.
  function automatic logic [2:0] pick_op(int mode);
    int w;
    int w2;
    int ins_w;
    int del_w;
    ins_w = (mode == 0) ? 60 : (mode == 1) ? 15 : 30;
    del_w = (mode == 0) ? 8 : (mode == 1) ? 45 : 20;
    w = $urandom_range(0, 99);
    if (w < ins_w) return OP_INS;
    if (w < ins_w + del_w) return OP_DEL;
    w2 = $urandom_range(0, 99);
    if (w2 < 25) return OP_GET;
    if (w2 < 45) return OP_LOC;
    if (w2 < 65) return OP_PRE;
    if (w2 < 85) return OP_SUC;
    if (w2 < 95) return OP_UNUSED;
    return (mode == 2) ? OP_CLR : OP_GET;
  endfunction

  task automatic random_command(int mode);
    logic [2:0]         op;
    logic [7:0]         pos;
    logic signed [31:0] val;
    op = pick_op(mode);
    case (op)
      OP_INS: begin
        pos = rand_position(list_sb.fill + 1);
        val = rand_word();
      end
      OP_DEL, OP_GET: begin
        pos = rand_position(list_sb.fill);
        val = $urandom;
      end
      default: begin
        // Searches hit a stored value most of the time.
        pos = 8'($urandom_range(0, 255));
        val = ($urandom_range(0, 9) < 6) ? list_sb.pick_present() : rand_word();
      end
    endcase
    pace_sender();
    issue_command(op, pos, val);
  endtask

  initial begin
    int mode;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty list, edges of the position range, extremes of the
    // word, duplicates, neighbor lookups at both ends, unused code, clear.
    issue_command(OP_GET, 8'd1, 32'sd0);
    issue_command(OP_DEL, 8'd1, 32'sd0);
    issue_command(OP_PRE, 8'd0, 32'sd0);
    issue_command(OP_INS, 8'd0, 32'sd5);
    issue_command(OP_INS, 8'd2, 32'sd5);
    issue_command(OP_INS, 8'd1, 32'sh7FFF_FFFF);
    issue_command(OP_INS, 8'd2, 32'sh8000_0000);
    issue_command(OP_INS, 8'd1, -32'sd1);
    issue_command(OP_INS, 8'd4, 32'sd0);
    issue_command(OP_INS, 8'd255, 32'sd9);
    issue_command(OP_GET, 8'd4, 32'sd0);
    issue_command(OP_GET, 8'd5, 32'sd0);
    issue_command(OP_LOC, 8'd0, 32'sh8000_0000);
    issue_command(OP_LOC, 8'd0, 32'sd12345);
    issue_command(OP_PRE, 8'd0, -32'sd1);
    issue_command(OP_PRE, 8'd0, 32'sh8000_0000);
    issue_command(OP_SUC, 8'd0, 32'sd0);
    issue_command(OP_SUC, 8'd0, -32'sd1);
    issue_command(OP_SUC, 8'd0, 32'sd777);
    issue_command(OP_INS, 8'd3, -32'sd1);
    issue_command(OP_LOC, 8'd0, -32'sd1);
    issue_command(OP_PRE, 8'd0, -32'sd1);
    issue_command(OP_DEL, 8'd3, 32'sd0);
    issue_command(OP_DEL, 8'd5, 32'sd0);
    issue_command(OP_UNUSED, 8'hFF, 32'shFFFF_FFFF);
    issue_command(OP_CLR, 8'd0, 32'sd0);
    wait_drained();

    mode = 0;
    for (int n = 0; n < 650; n++) begin
      if (n % 40 == 0) mode = $urandom_range(0, 2);
      if (n == 150) wait_drained();
      if (n == 300) begin
        // Fill the store to capacity, then work at the full boundary.
        while (list_sb.fill < LIST_CAP) begin
          pace_sender();
          issue_command(OP_INS, 8'($urandom_range(1, list_sb.fill + 1)), rand_word());
        end
        issue_command(OP_INS, 8'd1, rand_word());
        issue_command(OP_INS, 8'(LIST_CAP + 1), rand_word());
        issue_command(OP_GET, 8'(LIST_CAP), 32'sd0);
        issue_command(OP_SUC, 8'd0, list_sb.pick_present());
        issue_command(OP_PRE, 8'd0, list_sb.pick_present());
        issue_command(OP_DEL, 8'(LIST_CAP), 32'sd0);
        issue_command(OP_INS, 8'(LIST_CAP), rand_word());
        issue_command(OP_LOC, 8'd0, list_sb.pick_present());
        wait_drained();
        mode = 1;
      end
      random_command(mode);
    end

    wait_drained();
    repeat (LIST_CAP + 8) @(posedge clk);
    if (list_sb.errors == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
